[hdl/sorted_id_table_insert_unit_defines.svh]
// Assertion macros shared by the checker of the sorted identifier table.
// No dependencies; included by the files that carry assertions.
`ifndef SORTED_ID_TABLE_INSERT_UNIT_DEFINES_SVH
`define SORTED_ID_TABLE_INSERT_UNIT_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SITIU_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("sitiu assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define SITIU_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("sitiu assertion failed");

`endif

[hdl/sitiu_pkg.sv]
// Shared constants for the sorted identifier table insert unit.
// No dependencies; used by the top level and its checker.
`default_nettype none

package sitiu_pkg;

	localparam int ID_W = 16;
	localparam int TABLE_DEPTH_DEF = 32;

	localparam int MAX_ENTRIES_W = 6;
	localparam int SLOT_W = 5;
	localparam int TOTAL_W = 6;
	localparam int STATUS_W = 2;
	localparam int CFG_INDEX_W = 1;
	localparam int CFG_DATA_W = 6;

	localparam logic [ID_W-1:0] ASSIGN_CODE = 16'hFFFF;
	localparam logic [MAX_ENTRIES_W-1:0] MAX_ENTRIES_RST = 6'd32;

	localparam logic [STATUS_W-1:0] STAT_OK    = 2'd0;
	localparam logic [STATUS_W-1:0] STAT_FULL  = 2'd1;
	localparam logic [STATUS_W-1:0] STAT_DUP   = 2'd2;
	localparam logic [STATUS_W-1:0] STAT_NOSUP = 2'd3;

	localparam logic [CFG_INDEX_W-1:0] REG_MAX_ENTRIES    = 1'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_CREATE_ENABLED = 1'd1;

endpackage

`default_nettype wire

[hdl/sitiu_ram.sv]
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`default_nettype none

module sitiu_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 32,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

[hdl/sorted_id_table_insert_unit.sv]
// Sorted identifier table insert unit: top level with sequencer and table RAM.
// Depends on sitiu_pkg and sitiu_ram.
//
//  channel  | handshake            | payload
//  ---------+----------------------+---------------------------------------------
//  in       | in_valid / in_stall  | requested_id
//  out      | out_valid / out_stall| status, assigned_id, slot_index, entry_total
//  cfg      | cfg_valid / cfg_ready| cfg_index, cfg_data
//
// An item rejected as full goes straight to its result; any other item has a walk
// over the stored entries, then a shift of the entries above its slot (skipped
// on a reject), then its result. Items are taken one at a time, and the one RAM
// read port serves both the walk and the shift.
// Reset clears the count and sets the two configuration registers to their defaults; the table RAM is not cleared.
// A stalled result holds in the output register while the next item is taken.
`default_nettype none

module sorted_id_table_insert_unit #(
	parameter int TABLE_DEPTH = sitiu_pkg::TABLE_DEPTH_DEF
) (
	input  wire logic                                  clk,
	input  wire logic                                  arst_n,
	input  wire logic                                  in_valid,
	output logic                                       in_stall,
	input  wire logic [sitiu_pkg::ID_W-1:0]            requested_id,
	output logic                                       out_valid,
	input  wire logic                                  out_stall,
	output logic      [sitiu_pkg::STATUS_W-1:0]        status,
	output logic      [sitiu_pkg::ID_W-1:0]            assigned_id,
	output logic      [sitiu_pkg::SLOT_W-1:0]          slot_index,
	output logic      [sitiu_pkg::TOTAL_W-1:0]         entry_total,
	input  wire logic                                  cfg_valid,
	output logic                                       cfg_ready,
	input  wire logic [sitiu_pkg::CFG_INDEX_W-1:0]     cfg_index,
	input  wire logic [sitiu_pkg::CFG_DATA_W-1:0]      cfg_data
);

	localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int CW = $clog2(TABLE_DEPTH + 1);
	localparam int LW = (CW > sitiu_pkg::MAX_ENTRIES_W) ? CW : sitiu_pkg::MAX_ENTRIES_W;

	typedef enum logic [1:0] {
		S_IDLE,
		S_SCAN,
		S_SHIFT,
		S_FIN
	} state_t;

	state_t state_q;

	logic [sitiu_pkg::MAX_ENTRIES_W-1:0] max_entries_q;
	logic                                create_enabled_q;
	logic [CW-1:0]                       entry_count_q;

	logic [sitiu_pkg::ID_W-1:0] id_q;
	logic                       assign_q;
	logic                       found_q;
	logic                       dup_q;
	logic [AW-1:0]              slot_q;
	logic [CW-1:0]              ptr_q;
	logic [AW-1:0]              rptr_q;
	logic [CW-1:0]              left_q;
	logic [sitiu_pkg::STATUS_W-1:0] res_status_q;

	logic          rd_valid_s1;
	logic [AW-1:0] rd_idx_s1;

	logic [sitiu_pkg::STATUS_W-1:0] status_q;
	logic [sitiu_pkg::ID_W-1:0]     assigned_id_q;
	logic [sitiu_pkg::SLOT_W-1:0]   slot_index_q;
	logic [sitiu_pkg::TOTAL_W-1:0]  entry_total_q;
	logic                           out_valid_q;

	logic                       ram_we;
	logic [AW-1:0]              ram_waddr;
	logic [sitiu_pkg::ID_W-1:0] ram_wdata;
	logic [AW-1:0]              ram_raddr;
	logic [sitiu_pkg::ID_W-1:0] ram_rdata;

	logic in_acc;
	logic out_free;
	logic table_full;
	logic rd_issue;
	logic scan_done;
	logic shift_done;
	logic [AW-1:0]              slot_fin;
	logic [sitiu_pkg::ID_W-1:0] id_fin;

	sitiu_ram #(
		.WIDTH(sitiu_pkg::ID_W),
		.DEPTH(TABLE_DEPTH)
	) u_table (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	assign in_stall  = (state_q != S_IDLE);
	assign in_acc    = in_valid && !in_stall;
	assign cfg_ready = 1'b1;
	assign out_free  = !out_valid_q || !out_stall;

	assign out_valid   = out_valid_q;
	assign status      = status_q;
	assign assigned_id = assigned_id_q;
	assign slot_index  = slot_index_q;
	assign entry_total = entry_total_q;

	// The limit is the smaller of the configured maximum and the table depth.
	assign table_full = (LW'(entry_count_q) >= LW'(max_entries_q)) ||
		(entry_count_q >= CW'(TABLE_DEPTH));

	assign rd_issue = ((state_q == S_SCAN) && (ptr_q < entry_count_q)) ||
		((state_q == S_SHIFT) && (left_q != '0));
	assign ram_raddr  = (state_q == S_SCAN) ? ptr_q[AW-1:0] : rptr_q;
	assign scan_done  = (state_q == S_SCAN) && (ptr_q == entry_count_q) && !rd_valid_s1;
	assign shift_done = (state_q == S_SHIFT) && (left_q == '0) && !rd_valid_s1;

	// During the shift each returned entry moves up one slot; the final write
	// places the new identifier at its sorted position.
	assign ram_we    = (state_q == S_SHIFT) && (rd_valid_s1 || shift_done);
	assign ram_waddr = rd_valid_s1 ? (rd_idx_s1 + AW'(1)) : slot_q;
	assign ram_wdata = rd_valid_s1 ? ram_rdata : id_q;

	// With no entry above the identifier, it goes at the end of the table, and
	// an assigned identifier with no gap found equals the count.
	assign slot_fin = found_q ? slot_q : entry_count_q[AW-1:0];
	assign id_fin   = (assign_q && !found_q) ? sitiu_pkg::ID_W'(entry_count_q) : id_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q          <= S_IDLE;
			max_entries_q    <= sitiu_pkg::MAX_ENTRIES_RST;
			create_enabled_q <= 1'b1;
			entry_count_q    <= '0;
			rd_valid_s1      <= 1'b0;
			out_valid_q      <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					sitiu_pkg::REG_MAX_ENTRIES: begin
						max_entries_q <= cfg_data;
					end
					sitiu_pkg::REG_CREATE_ENABLED: begin
						create_enabled_q <= cfg_data[0];
					end
					default: begin
					end
				endcase
			end

			rd_valid_s1 <= rd_issue;
			rd_idx_s1   <= ram_raddr;
			if (rd_issue && (state_q == S_SHIFT)) begin
				rptr_q <= rptr_q - AW'(1);
				left_q <= left_q - CW'(1);
			end

			if ((state_q == S_FIN) && out_free) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end

			case (state_q)
				S_IDLE: begin
					if (in_acc) begin
						id_q     <= requested_id;
						assign_q <= (requested_id == sitiu_pkg::ASSIGN_CODE);
						found_q  <= 1'b0;
						dup_q    <= 1'b0;
						ptr_q    <= '0;
						if (table_full) begin
							res_status_q <= sitiu_pkg::STAT_FULL;
							state_q      <= S_FIN;
						end else begin
							state_q <= S_SCAN;
						end
					end
				end
				S_SCAN: begin
					if (rd_issue) begin
						ptr_q <= ptr_q + CW'(1);
					end
					// The first entry that breaks the run 0,1,2,... marks the
					// lowest free identifier; for a requested identifier the
					// first entry at or above it ends the search.
					if (rd_valid_s1 && !found_q) begin
						if (assign_q) begin
							if (ram_rdata != sitiu_pkg::ID_W'(rd_idx_s1)) begin
								found_q <= 1'b1;
								slot_q  <= rd_idx_s1;
								id_q    <= sitiu_pkg::ID_W'(rd_idx_s1);
							end
						end else if (ram_rdata == id_q) begin
							found_q <= 1'b1;
							dup_q   <= 1'b1;
						end else if (ram_rdata > id_q) begin
							found_q <= 1'b1;
							slot_q  <= rd_idx_s1;
						end
					end
					if (scan_done) begin
						slot_q <= slot_fin;
						id_q   <= id_fin;
						left_q <= entry_count_q - CW'(slot_fin);
						rptr_q <= entry_count_q[AW-1:0] - AW'(1);
						if (dup_q) begin
							res_status_q <= sitiu_pkg::STAT_DUP;
							state_q      <= S_FIN;
						end else if (!create_enabled_q) begin
							res_status_q <= sitiu_pkg::STAT_NOSUP;
							state_q      <= S_FIN;
						end else begin
							res_status_q <= sitiu_pkg::STAT_OK;
							state_q      <= S_SHIFT;
						end
					end
				end
				S_SHIFT: begin
					if (shift_done) begin
						entry_count_q <= entry_count_q + CW'(1);
						state_q       <= S_FIN;
					end
				end
				S_FIN: begin
					if (out_free) begin
						status_q      <= res_status_q;
						entry_total_q <= sitiu_pkg::TOTAL_W'(entry_count_q);
						if (res_status_q == sitiu_pkg::STAT_OK) begin
							assigned_id_q <= id_q;
							slot_index_q  <= sitiu_pkg::SLOT_W'(slot_q);
						end else begin
							assigned_id_q <= '0;
							slot_index_q  <= '0;
						end
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

`default_nettype wire

[hdl/sitiu_checker.sv]
// Port-level checker for the sorted identifier table insert unit, with its bind.
// Depends on sitiu_pkg and sorted_id_table_insert_unit_defines.svh.
`default_nettype none
`include "sorted_id_table_insert_unit_defines.svh"

module sitiu_checker (
	input wire logic                               clk,
	input wire logic                               arst_n,
	input wire logic                               in_valid,
	input wire logic                               in_stall,
	input wire logic                               out_valid,
	input wire logic                               out_stall,
	input wire logic [sitiu_pkg::STATUS_W-1:0]     status,
	input wire logic [sitiu_pkg::ID_W-1:0]         assigned_id,
	input wire logic [sitiu_pkg::SLOT_W-1:0]       slot_index,
	input wire logic [sitiu_pkg::TOTAL_W-1:0]      entry_total
);

	// The block works on one item at a time, so it is busy right after taking one.
	`SITIU_ASSERT_NEXT(a_busy_after_accept, clk, arst_n, in_valid && !in_stall, in_stall)

	// A rejected item reports no identifier and no slot.
	`SITIU_ASSERT_NOW(a_reject_clean, clk, arst_n, out_valid && (status != sitiu_pkg::STAT_OK), (assigned_id == '0) && (slot_index == '0))

	// A stalled result stays in place.
	`SITIU_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && out_stall, out_valid && $stable(status) && $stable(assigned_id) && $stable(slot_index) && $stable(entry_total))

endmodule

bind sorted_id_table_insert_unit sitiu_checker u_sitiu_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_valid   (in_valid),
	.in_stall   (in_stall),
	.out_valid  (out_valid),
	.out_stall  (out_stall),
	.status     (status),
	.assigned_id(assigned_id),
	.slot_index (slot_index),
	.entry_total(entry_total)
);

`default_nettype wire

[dv/tb_sorted_id_table_insert_unit.sv]
// Testbench for the sorted identifier table insert unit: directed and random create
// requests checked field by field against a behavioral model of the table kept here.
// Depends on sitiu_pkg and sorted_id_table_insert_unit.
`default_nettype none

module tb_sorted_id_table_insert_unit;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int DEPTH = sitiu_pkg::TABLE_DEPTH_DEF;
	localparam int REQUEST_TARGET = 1050;
	localparam int HANG_LIMIT = 1000;
	localparam int MAX_PRINTS = 60;

	typedef struct packed {
		logic [sitiu_pkg::STATUS_W-1:0] status;
		logic [sitiu_pkg::ID_W-1:0]     id;
		logic [sitiu_pkg::SLOT_W-1:0]   slot;
		logic [sitiu_pkg::TOTAL_W-1:0]  total;
	} create_result_t;

	logic                              clk = 1'b0;
	logic                              arst_n = 1'b0;
	logic                              in_valid = 1'b0;
	logic                              in_stall;
	logic [sitiu_pkg::ID_W-1:0]        requested_id = '0;
	logic                              out_valid;
	logic                              out_stall = 1'b0;
	logic [sitiu_pkg::STATUS_W-1:0]    status;
	logic [sitiu_pkg::ID_W-1:0]        assigned_id;
	logic [sitiu_pkg::SLOT_W-1:0]      slot_index;
	logic [sitiu_pkg::TOTAL_W-1:0]     entry_total;
	logic                              cfg_valid = 1'b0;
	logic                              cfg_ready;
	logic [sitiu_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
	logic [sitiu_pkg::CFG_DATA_W-1:0]  cfg_data = '0;

	// Model copy of the table, its count and the two registers.
	logic [sitiu_pkg::ID_W-1:0] id_model [DEPTH];
	int                         stored_count = 0;
	int                         limit_reg = int'(sitiu_pkg::MAX_ENTRIES_RST);
	bit                         create_on = 1'b1;

	logic [sitiu_pkg::ID_W-1:0] pending_ids [$];
	create_result_t             expected_results [$];
	int                         error_count = 0;
	int                         requests_sent = 0;
	bit                         send_gaps = 1'b1;
	bit                         recv_gaps = 1'b1;
	int                         send_wait = 0;
	int                         recv_wait = 0;
	int                         idle_cycles = 0;

	sorted_id_table_insert_unit #(.TABLE_DEPTH(DEPTH)) u_top (.*);

	initial begin
		forever #5 clk = ~clk;
	end

	task automatic report_mismatch(input string what, input int got, input int want);
		if (error_count < MAX_PRINTS)
			$display("%0t: %s mismatch, got %0d expected %0d", $time, what, got, want);
		error_count++;
	endtask

	// Applies one create request to the model table and returns the result it gives.
	function automatic create_result_t apply_create(input logic [sitiu_pkg::ID_W-1:0] req);
		create_result_t r;
		logic [sitiu_pkg::ID_W-1:0] id;
		int limit;
		int pos;
		int k;
		bit hit;
		r = '0;
		r.status = sitiu_pkg::STAT_OK;
		id = req;
		limit = (limit_reg < DEPTH) ? limit_reg : DEPTH;
		if (stored_count >= limit) begin
			r.status = sitiu_pkg::STAT_FULL;
		end else begin
			if (id == sitiu_pkg::ASSIGN_CODE) begin
				k = 0;
				while (k < stored_count && id_model[k] == sitiu_pkg::ID_W'(k))
					k++;
				id = sitiu_pkg::ID_W'(k);
			end else begin
				hit = 1'b0;
				for (k = 0; k < stored_count; k++)
					if (id_model[k] == id)
						hit = 1'b1;
				if (hit)
					r.status = sitiu_pkg::STAT_DUP;
			end
			if (r.status == sitiu_pkg::STAT_OK && !create_on)
				r.status = sitiu_pkg::STAT_NOSUP;
		end
		if (r.status == sitiu_pkg::STAT_OK) begin
			pos = stored_count;
			for (k = stored_count - 1; k >= 0; k--)
				if (id_model[k] > id)
					pos = k;
			for (k = stored_count; k > pos; k--)
				id_model[k] = id_model[k-1];
			id_model[pos] = id;
			stored_count++;
			r.id = id;
			r.slot = sitiu_pkg::SLOT_W'(pos);
		end
		r.total = sitiu_pkg::TOTAL_W'(stored_count);
		return r;
	endfunction

	// Mix of duplicates, near misses, assign requests and free values.
	function automatic logic [sitiu_pkg::ID_W-1:0] pick_id();
		int sel;
		logic [sitiu_pkg::ID_W-1:0] base;
		sel = $urandom_range(0, 9);
		if (stored_count != 0 && sel < 4) begin
			base = id_model[$urandom_range(0, stored_count - 1)];
			if (sel < 2)
				return base;
			return $urandom_range(0, 1) ? base + 1'b1 : base - 1'b1;
		end
		if (sel < 6)
			return sitiu_pkg::ASSIGN_CODE;
		if (sel < 8)
			return sitiu_pkg::ID_W'($urandom_range(0, 40));
		return sitiu_pkg::ID_W'($urandom());
	endfunction

	// The write channel drops for one cycle after each write.
	task automatic write_reg(input logic [sitiu_pkg::CFG_INDEX_W-1:0] idx,
			input logic [sitiu_pkg::CFG_DATA_W-1:0] data);
		cfg_index <= idx;
		cfg_data <= data;
		cfg_valid <= 1'b1;
		do
			@(posedge clk);
		while (!cfg_ready);
		cfg_valid <= 1'b0;
		if (idx == sitiu_pkg::REG_MAX_ENTRIES)
			limit_reg = int'(data);
		else
			create_on = data[0];
		@(posedge clk);
	endtask

	// Holds the sender back until every outstanding item has produced its result.
	task automatic settle();
		while (pending_ids.size() != 0 || in_valid || expected_results.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	always @(posedge clk or negedge arst_n) begin
		bit took;
		int gap;
		if (!arst_n) begin
			in_valid <= 1'b0;
			requested_id <= '0;
			send_wait <= 0;
		end else begin
			took = in_valid && !in_stall;
			gap = send_wait;
			if (took) begin
				expected_results.push_back(apply_create(requested_id));
				gap = send_gaps ? $urandom_range(0, 11) : 0;
			end
			// A stalled item keeps its payload until it is taken.
			if (!in_valid || took) begin
				if (gap != 0) begin
					in_valid <= 1'b0;
					send_wait <= gap - 1;
				end else if (pending_ids.size() != 0) begin
					in_valid <= 1'b1;
					requested_id <= pending_ids.pop_front();
					send_wait <= 0;
				end else begin
					in_valid <= 1'b0;
					send_wait <= 0;
				end
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		int wait_v;
		create_result_t want;
		if (!arst_n) begin
			out_stall <= 1'b0;
			recv_wait <= 0;
		end else begin
			wait_v = recv_wait;
			if (out_valid && !out_stall) begin
				if (expected_results.size() == 0) begin
					report_mismatch("unexpected result, status", status, 0);
				end else begin
					want = expected_results.pop_front();
					if (status !== want.status)
						report_mismatch("status", status, want.status);
					if (assigned_id !== want.id)
						report_mismatch("assigned_id", assigned_id, want.id);
					if (slot_index !== want.slot)
						report_mismatch("slot_index", slot_index, want.slot);
					if (entry_total !== want.total)
						report_mismatch("entry_total", entry_total, want.total);
				end
				wait_v = recv_gaps ? $urandom_range(0, 11) : 0;
			end
			out_stall <= (wait_v != 0);
			recv_wait <= (wait_v != 0) ? wait_v - 1 : 0;
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall)
				|| (cfg_valid && cfg_ready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= HANG_LIMIT) begin
			$display("RESULT: ERROR");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	initial begin
		int n;
		int mode;
		int lim;
		bit en;
		logic [sitiu_pkg::CFG_DATA_W-1:0] en_data;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// A zero limit rejects everything as full.
		write_reg(sitiu_pkg::REG_MAX_ENTRIES, 6'd0);
		pending_ids.push_back(16'h0000);
		pending_ids.push_back(sitiu_pkg::ASSIGN_CODE);
		settle();

		// Limit above the table depth, creates switched off.
		write_reg(sitiu_pkg::REG_MAX_ENTRIES, 6'd63);
		write_reg(sitiu_pkg::REG_CREATE_ENABLED, 6'b111110);
		pending_ids.push_back(16'h1234);
		pending_ids.push_back(sitiu_pkg::ASSIGN_CODE);
		settle();

		// Assignment, insertion at both ends and in the middle, duplicates.
		write_reg(sitiu_pkg::REG_CREATE_ENABLED, 6'd1);
		pending_ids.push_back(sitiu_pkg::ASSIGN_CODE);
		pending_ids.push_back(sitiu_pkg::ASSIGN_CODE);
		pending_ids.push_back(16'hFFFE);
		pending_ids.push_back(16'h0005);
		pending_ids.push_back(16'h0003);
		pending_ids.push_back(16'h0003);
		pending_ids.push_back(sitiu_pkg::ASSIGN_CODE);
		pending_ids.push_back(16'h8000);
		pending_ids.push_back(16'h7FFF);
		pending_ids.push_back(16'h5555);
		pending_ids.push_back(16'hAAAA);
		pending_ids.push_back(16'h0001);
		pending_ids.push_back(16'hFFFE);
		pending_ids.push_back(16'h0000);
		settle();

		// A duplicate is reported ahead of the disabled create.
		write_reg(sitiu_pkg::REG_CREATE_ENABLED, 6'd0);
		pending_ids.push_back(16'h0005);
		pending_ids.push_back(16'h0004);
		settle();

		// Limit written below the current count.
		write_reg(sitiu_pkg::REG_CREATE_ENABLED, 6'd1);
		write_reg(sitiu_pkg::REG_MAX_ENTRIES, 6'd4);
		pending_ids.push_back(16'h0004);
		pending_ids.push_back(sitiu_pkg::ASSIGN_CODE);
		settle();

		// Random phases. Most phases allow only a few more entries, so the table
		// fills slowly and duplicates and disabled creates get exercised on the way.
		while (requests_sent < REQUEST_TARGET) begin
			mode = $urandom_range(0, 9);
			case (mode)
				0: lim = 0;
				1: lim = 63;
				2: lim = $urandom_range(0, 63);
				default: lim = stored_count + $urandom_range(0, 3);
			endcase
			if (mode >= 3 || requests_sent > (REQUEST_TARGET * 3) / 4)
				en = ($urandom_range(0, 3) != 0);
			else
				en = 1'b0;
			en_data = sitiu_pkg::CFG_DATA_W'($urandom());
			en_data[0] = en;
			write_reg(sitiu_pkg::REG_MAX_ENTRIES, sitiu_pkg::CFG_DATA_W'(lim));
			write_reg(sitiu_pkg::REG_CREATE_ENABLED, en_data);
			send_gaps = ($urandom_range(0, 3) != 0);
			recv_gaps = ($urandom_range(0, 3) != 0);
			n = $urandom_range(10, 60);
			repeat (n)
				pending_ids.push_back(pick_id());
			requests_sent += n;
			settle();
		end

		repeat (80) @(posedge clk);
		if (error_count == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule

`default_nettype wire

[filelist.f]
+incdir+hdl
hdl/sitiu_pkg.sv
hdl/sitiu_ram.sv
hdl/sorted_id_table_insert_unit.sv
hdl/sitiu_checker.sv
dv/tb_sorted_id_table_insert_unit.sv
